// ===== rtl/core/pec15_pkg.sv =====
// Shared types, constants and the CRC table function for the PEC15 frame appender.
// No dependencies.
package pec15_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h4599;
    localparam logic [15:0] CRC_SEED   = 16'd16;
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] pec;
    } entry_t;

    // one table entry: idx << 7 run through 8 shifts, no 15-bit mask
    function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
        logic [15:0] r;
        r = {1'b0, idx, 7'b0};
        for (int b = 0; b < 8; b++)
        begin
            if (r[14])
            begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pec15_front.sv =====
// Front end: accepts input words, runs the byte-wise CRC update, queues word plus PEC.
// Depends on pec15_pkg.
module pec15_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic                 q_full,
    output logic                 full,
    output logic                 q_wr,
    output pec15_pkg::entry_t    q_wdata
);

    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [15:0] rem_upd;
    logic [7:0]  idx;

    assign full  = q_full;
    assign q_wr  = push && !q_full;
    assign idx   = rem_reg[14:7] ^ data_byte;
    assign rem_upd = {rem_reg[7:0], 8'h00} ^ pec15_pkg::crc_table_entry(idx);

    always_comb
    begin
        rem_next = rem_reg;
        if (q_wr)
        begin
            rem_next = last_byte ? pec15_pkg::CRC_SEED : rem_upd;
        end
    end

    assign q_wdata.data = data_byte;
    assign q_wdata.last = last_byte;
    assign q_wdata.pec  = {rem_upd[14:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= pec15_pkg::CRC_SEED;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/core/pec15_fifo.sv =====
// Short queue between front and back ends.
// Depends on pec15_pkg.
module pec15_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  pec15_pkg::entry_t    wdata,
    output logic                 full,
    input  logic                 rd,
    output pec15_pkg::entry_t    rdata,
    output logic                 empty
);

    pec15_pkg::entry_t                 mem [pec15_pkg::FIFO_DEPTH];
    logic [pec15_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [pec15_pkg::FIFO_AW-1:0]     wr_ptr_next;
    logic [pec15_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [pec15_pkg::FIFO_AW-1:0]     rd_ptr_next;
    logic [pec15_pkg::FIFO_CW-1:0]     cnt_reg;
    logic [pec15_pkg::FIFO_CW-1:0]     cnt_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full  = (cnt_reg == pec15_pkg::FIFO_CW'(pec15_pkg::FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == pec15_pkg::FIFO_AW'(pec15_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == pec15_pkg::FIFO_AW'(pec15_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/pec15_back.sv =====
// Back end: drains queued words into the output register, appending PEC high/low after last.
// Depends on pec15_pkg.
module pec15_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  pec15_pkg::entry_t    q_rdata,
    output logic                 q_rd,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           out_byte,
    output logic                 is_pec,
    output logic                 frame_end
);

    typedef enum logic [1:0]
    {
        ST_ECHO,
        ST_HI,
        ST_LO
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        pec_reg;
    logic        pec_next;
    logic        end_reg;
    logic        end_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        slot_free;

    assign empty     = !valid_reg;
    assign out_byte  = byte_reg;
    assign is_pec    = pec_reg;
    assign frame_end = end_reg;
    assign slot_free = !valid_reg || pop;
    assign q_rd      = slot_free && (state_reg == ST_ECHO) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && !pop;
        byte_next  = byte_reg;
        pec_next   = pec_reg;
        end_next   = end_reg;
        crc_next   = crc_reg;
        if (slot_free)
        begin
            case (state_reg)
                ST_ECHO:
                begin
                    if (!q_empty)
                    begin
                        valid_next = 1'b1;
                        byte_next  = q_rdata.data;
                        pec_next   = 1'b0;
                        end_next   = 1'b0;
                        crc_next   = q_rdata.pec;
                        if (q_rdata.last)
                        begin
                            state_next = ST_HI;
                        end
                    end
                end
                ST_HI:
                begin
                    valid_next = 1'b1;
                    byte_next  = crc_reg[15:8];
                    pec_next   = 1'b1;
                    end_next   = 1'b0;
                    state_next = ST_LO;
                end
                ST_LO:
                begin
                    valid_next = 1'b1;
                    byte_next  = crc_reg[7:0];
                    pec_next   = 1'b1;
                    end_next   = 1'b1;
                    state_next = ST_ECHO;
                end
                default:
                begin
                    state_next = ST_ECHO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ECHO;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            pec_reg   <= 1'b0;
            end_reg   <= 1'b0;
            crc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            pec_reg   <= pec_next;
            end_reg   <= end_next;
            crc_reg   <= crc_next;
        end
    end

    a_end_is_pec: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && end_reg |-> pec_reg)
        else $error("frame_end without is_pec");

    a_hi_shows_echo: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HI |-> valid_reg && !pec_reg)
        else $error("last echo not held while PEC pending");

    a_lo_shows_hi: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LO |-> valid_reg && pec_reg && !end_reg)
        else $error("PEC high byte not held before low byte");

    a_no_read_in_pec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_ECHO |-> !q_rd)
        else $error("queue read during PEC emission");

endmodule

// ===== rtl/core/pec15_frame_appender.sv =====
// Top level of the PEC15 frame appender.
// Depends on pec15_pkg, pec15_front, pec15_fifo, pec15_back.
// Each pushed byte is echoed, and after a byte marked last the 16-bit PEC (polynomial 0x4599,
// seed 16, remainder shifted left by one) follows as two more words, high byte first, the low
// one flagged frame_end. The CRC update is one table lookup per byte in the front end, so one
// byte is accepted every cycle while the 4-entry queue has room; the back end delivers one word
// per cycle while pop is held and the queue has words, so a frame of N bytes leaves as N + 2
// words. The echo of a byte passes through the queue and then the output register on its way out.
module pec15_frame_appender
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        is_pec,
    output logic        frame_end
);

    logic                 q_wr;
    logic                 q_full;
    logic                 q_rd;
    logic                 q_empty;
    pec15_pkg::entry_t    q_wdata;
    pec15_pkg::entry_t    q_rdata;

    pec15_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .full      (full),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata)
    );

    pec15_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    pec15_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .is_pec    (is_pec),
        .frame_end (frame_end)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for pec15_frame_appender: directed and random frames with random push/pop gaps.
// A scoreboard class predicts the echo and PEC15 words; depends on pec15_pkg and the RTL.
module tb_top;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 500;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [7:0] value;
        logic       pec;
        logic       fin;
    } word_t;

    class frame_pec_tracker;
        logic [15:0] crc_lut [256];
        logic [15:0] rem;
        word_t       expected_words [$];
        int          errors;
        int          checked;
        int          frames;
        int          bytes_in;

        function new();
            logic [15:0] v;
            for (int i = 0; i < 256; i++)
            begin
                v = 16'(i) << 7;
                repeat (8)
                begin
                    v = v[14] ? ((v << 1) ^ pec15_pkg::CRC_POLY) : (v << 1);
                end
                crc_lut[i] = v;
            end
            rem      = pec15_pkg::CRC_SEED;
            errors   = 0;
            checked  = 0;
            frames   = 0;
            bytes_in = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [7:0]  idx;
            logic [15:0] pec;
            word_t       w;
            idx = rem[14:7] ^ b;
            rem = {rem[7:0], 8'h00} ^ crc_lut[idx];
            w.value = b;
            w.pec   = 1'b0;
            w.fin   = 1'b0;
            expected_words.push_back(w);
            bytes_in++;
            if (last)
            begin
                pec     = {rem[14:0], 1'b0};
                w.value = pec[15:8];
                w.pec   = 1'b1;
                expected_words.push_back(w);
                w.value = pec[7:0];
                w.fin   = 1'b1;
                expected_words.push_back(w);
                rem = pec15_pkg::CRC_SEED;
                frames++;
            end
        endfunction

        function void check_word(logic [7:0] b, logic p, logic f);
            word_t w;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word out_byte=%02h is_pec=%0b frame_end=%0b",
                         $time, b, p, f);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            checked++;
            if (b !== w.value)
            begin
                $display("%0t: out_byte expected %02h got %02h", $time, w.value, b);
                errors++;
            end
            if (p !== w.pec)
            begin
                $display("%0t: is_pec expected %0b got %0b", $time, w.pec, p);
                errors++;
            end
            if (f !== w.fin)
            begin
                $display("%0t: frame_end expected %0b got %0b", $time, w.fin, f);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       empty;
    logic       pop       = 1'b0;
    logic [7:0] out_byte;
    logic       is_pec;
    logic       frame_end;

    bit         steady = 1'b0;
    int         cycles = 0;
    frame_pec_tracker tracker = new();

    pec15_frame_appender i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .is_pec    (is_pec),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check on accept, then pick next pop
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                tracker.check_word(out_byte, is_pec, frame_end);
            end
            pop <= steady || ($urandom_range(99) >= 17);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 17)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (full);
        tracker.note_byte(b, last);
    endtask

    // hold off until every expected word is out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int sent;
        int len;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // single- and multi-byte frames, extremes, alternating and single-bit patterns
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        wait_drained();

        while (sent < RANDOM_BYTES)
        begin
            steady = (sent >= 200 && sent < 320);
            if (!paused && sent >= 350)
            begin
                wait_drained();
                paused = 1'b1;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                send_byte(8'($urandom_range(255)), k == len - 1);
            end
            sent += len;
        end
        steady = 1'b0;
        push <= 1'b0;

        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d frames, %0d words checked, %0d mismatches",
                 tracker.bytes_in, tracker.frames, tracker.checked, tracker.errors);
        if (tracker.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
